FILE: sv/dad_pkg.sv
// Shared types, constants and helper functions for the date advance block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package dad_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int COUNT_W = 16;

    // Microprogram layout.
    localparam int STEP_W = 4;
    localparam int ARG_W  = 3;
    localparam logic [STEP_W-1:0] STEP_LOAD = 4'd0;
    localparam logic [STEP_W-1:0] STEP_WALK = 4'd8;
    localparam logic [STEP_W-1:0] STEP_OUT  = 4'd9;
    localparam logic [STEP_W-1:0] STEP_LAST = 4'd9;

    // Months and the 400-year leap cycle.
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam int CYCLE_W = 9;
    localparam logic [CYCLE_W-1:0] CYCLE_LAST = 9'd399;
    localparam logic [CYCLE_W-1:0] CENTURY_1  = 9'd100;
    localparam logic [CYCLE_W-1:0] CENTURY_2  = 9'd200;
    localparam logic [CYCLE_W-1:0] CENTURY_3  = 9'd300;
    localparam int REDUCE_STEPS = 6;
    localparam logic [YEAR_W-1:0] CYCLE_LEN = 14'd400;

    typedef enum logic [2:0] {
        OP_LOAD,
        OP_REDUCE,
        OP_CLAMP,
        OP_WALK,
        OP_OUT
    } op_t;

    typedef enum logic [1:0] {
        COND_NEVER,
        COND_NO_INPUT,
        COND_BUSY,
        COND_OUT_BLOCKED
    } cond_t;

    typedef struct packed {
        op_t                op;
        logic [ARG_W-1:0]   arg;
        cond_t              cond;
        logic [STEP_W-1:0]  target;
    } ctrl_word_t;

    typedef struct packed {
        logic in_valid;
        logic left_busy;
        logic out_blocked;
    } dad_status_t;

    // Subtrahend for reduction step idx: 400 shifted left by (5 - idx).
    function automatic logic [YEAR_W-1:0] reduce_sub(input logic [ARG_W-1:0] idx);
        logic [ARG_W-1:0] sh;
        sh = ARG_W'(REDUCE_STEPS - 1) - idx;
        return CYCLE_LEN << sh;
    endfunction

    // Leap test on the year position within the 400-year cycle.
    function automatic logic is_leap(input logic [CYCLE_W-1:0] pos);
        logic century;
        century = (pos == CENTURY_1) || (pos == CENTURY_2) || (pos == CENTURY_3);
        return (pos == '0) || (!century && (pos[1:0] == 2'b00));
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        len = 5'd31;
        if (m == MONTH_FEB) begin
            len = leap ? 5'd29 : 5'd28;
        end else if (m inside {MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV}) begin
            len = 5'd30;
        end
        return len;
    endfunction

endpackage

FILE: sv/date_add_days_top.sv
// Usage notes for date_add_days_top.
// Input channel s_*: a start date (day, month, year) and a day count, one
// transfer at a time. Result channel m_*: the date that many days later.
// Out-of-range start fields are normalized first (month 0 becomes January,
// month above 12 becomes December, day 0 becomes 1, a day past the month end
// becomes the last day), so every result is a valid date.
// After its input transfer each item runs through the sequencer steps: six
// reduction steps reduce the year modulo 400, one clamps the day, then the
// walk takes one step per month boundary crossed, plus one when the count
// ends inside a month (none for a zero count), one more step leaves the walk
// and one loads the output register once the previous result is transferred.
// s_ready is high only while the sequencer waits at its load step, so one
// item is in work at a time and a new input transfer can follow only once
// the previous item has left the output step. A finished result sits in
// the output register; the next item may already be taken and worked on
// while the receiver stalls, and its result waits until the previous one
// is transferred. Reset (aresetn low, synchronous) returns the sequencer
// to the load step and drops m_valid.
// Depends on dad_pkg, dad_seq, dad_rom and dad_datapath.
`timescale 1ns / 1ps

module date_add_days_top
    import dad_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [DAY_W-1:0]   s_start_day,
    input  logic [MONTH_W-1:0] s_start_month,
    input  logic [YEAR_W-1:0]  s_start_year,
    input  logic [COUNT_W-1:0] s_days_to_add,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [DAY_W-1:0]   m_end_day,
    output logic [MONTH_W-1:0] m_end_month,
    output logic [YEAR_W-1:0]  m_end_year
);

    ctrl_word_t  ctrl;
    dad_status_t status;
    logic        left_busy;
    logic        out_blocked;

    assign status = '{in_valid: s_valid, left_busy: left_busy, out_blocked: out_blocked};

    dad_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    dad_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctrl          (ctrl),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_start_day   (s_start_day),
        .s_start_month (s_start_month),
        .s_start_year  (s_start_year),
        .s_days_to_add (s_days_to_add),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_end_day     (m_end_day),
        .m_end_month   (m_end_month),
        .m_end_year    (m_end_year),
        .left_busy     (left_busy),
        .out_blocked   (out_blocked)
    );

endmodule

FILE: sv/dad_rom.sv
// Microcode ROM of the date advance sequencer: one control word per step.
// Depends on dad_pkg for the control word layout and step numbers.
`timescale 1ns / 1ps

module dad_rom
    import dad_pkg::*;
(
    input  logic [STEP_W-1:0] step,
    output ctrl_word_t        ctrl
);

    always_comb begin
        case (step)
            4'd0:    ctrl = '{op: OP_LOAD,   arg: 3'd0, cond: COND_NO_INPUT,    target: STEP_LOAD};
            4'd1:    ctrl = '{op: OP_REDUCE, arg: 3'd0, cond: COND_NEVER,       target: STEP_LOAD};
            4'd2:    ctrl = '{op: OP_REDUCE, arg: 3'd1, cond: COND_NEVER,       target: STEP_LOAD};
            4'd3:    ctrl = '{op: OP_REDUCE, arg: 3'd2, cond: COND_NEVER,       target: STEP_LOAD};
            4'd4:    ctrl = '{op: OP_REDUCE, arg: 3'd3, cond: COND_NEVER,       target: STEP_LOAD};
            4'd5:    ctrl = '{op: OP_REDUCE, arg: 3'd4, cond: COND_NEVER,       target: STEP_LOAD};
            4'd6:    ctrl = '{op: OP_REDUCE, arg: 3'd5, cond: COND_NEVER,       target: STEP_LOAD};
            4'd7:    ctrl = '{op: OP_CLAMP,  arg: 3'd0, cond: COND_NEVER,       target: STEP_LOAD};
            4'd8:    ctrl = '{op: OP_WALK,   arg: 3'd0, cond: COND_BUSY,        target: STEP_WALK};
            4'd9:    ctrl = '{op: OP_OUT,    arg: 3'd0, cond: COND_OUT_BLOCKED, target: STEP_OUT};
            default: ctrl = '{op: OP_OUT,    arg: 3'd0, cond: COND_NEVER,       target: STEP_LOAD};
        endcase
    end

endmodule

FILE: sv/dad_seq.sv
// Step counter and jump logic of the date advance sequencer.
// Depends on dad_pkg and the microcode ROM dad_rom.
`timescale 1ns / 1ps

module dad_seq
    import dad_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  dad_status_t status,
    output ctrl_word_t  ctrl
);

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              take;

    dad_rom u_rom (
        .step (step_reg),
        .ctrl (ctrl)
    );

    always_comb begin
        case (ctrl.cond)
            COND_NO_INPUT:    take = !status.in_valid;
            COND_BUSY:        take = status.left_busy;
            COND_OUT_BLOCKED: take = status.out_blocked;
            default:          take = 1'b0;
        endcase
    end

    always_comb begin
        if (take) begin
            step_next = ctrl.target;
        end else if (step_reg == STEP_LAST) begin
            step_next = STEP_LOAD;
        end else begin
            step_next = step_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_LOAD;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

FILE: sv/dad_datapath.sv
// Datapath of the date advance block: date and count registers, leap-cycle
// position, month-length logic and the output register. Depends on dad_pkg.
`timescale 1ns / 1ps

module dad_datapath
    import dad_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  ctrl_word_t         ctrl,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [DAY_W-1:0]   s_start_day,
    input  logic [MONTH_W-1:0] s_start_month,
    input  logic [YEAR_W-1:0]  s_start_year,
    input  logic [COUNT_W-1:0] s_days_to_add,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [DAY_W-1:0]   m_end_day,
    output logic [MONTH_W-1:0] m_end_month,
    output logic [YEAR_W-1:0]  m_end_year,
    output logic               left_busy,
    output logic               out_blocked
);

    logic [DAY_W-1:0]   day_reg,   day_next;
    logic [MONTH_W-1:0] month_reg, month_next;
    logic [YEAR_W-1:0]  year_reg,  year_next;
    logic [COUNT_W-1:0] left_reg,  left_next;
    logic [YEAR_W-1:0]  pos_reg,   pos_next;
    logic               m_valid_reg, m_valid_next;
    logic [DAY_W-1:0]   m_day_reg;
    logic [MONTH_W-1:0] m_month_reg;
    logic [YEAR_W-1:0]  m_year_reg;

    logic [DAY_W-1:0]   len;
    logic [COUNT_W:0]   reach;
    logic [DAY_W:0]     gap;
    logic [YEAR_W-1:0]  sub;
    logic               out_load;

    assign s_ready     = (ctrl.op == OP_LOAD);
    assign left_busy   = (left_reg != '0);
    assign out_blocked = m_valid_reg && !m_ready;
    assign out_load    = (ctrl.op == OP_OUT) && !out_blocked;

    // After the reduction steps pos_reg holds the year modulo 400.
    assign len   = month_len(month_reg, is_leap(pos_reg[CYCLE_W-1:0]));
    assign reach = {12'd0, day_reg} + {1'b0, left_reg};
    assign gap   = {1'b0, len} + 6'd1 - {1'b0, day_reg};
    assign sub   = reduce_sub(ctrl.arg);

    always_comb begin
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        left_next  = left_reg;
        pos_next   = pos_reg;
        case (ctrl.op)
            OP_LOAD: begin
                if (s_valid) begin
                    day_next  = (s_start_day == '0) ? 5'd1 : s_start_day;
                    year_next = s_start_year;
                    pos_next  = s_start_year;
                    left_next = s_days_to_add;
                    if (s_start_month == '0) begin
                        month_next = MONTH_JAN;
                    end else if (s_start_month > MONTH_DEC) begin
                        month_next = MONTH_DEC;
                    end else begin
                        month_next = s_start_month;
                    end
                end
            end
            OP_REDUCE: begin
                if (pos_reg >= sub) begin
                    pos_next = pos_reg - sub;
                end
            end
            OP_CLAMP: begin
                if (day_reg > len) begin
                    day_next = len;
                end
            end
            OP_WALK: begin
                if (left_busy) begin
                    if (reach > {12'd0, len}) begin
                        // Move to the first of the next month.
                        left_next = left_reg - {10'd0, gap};
                        day_next  = 5'd1;
                        if (month_reg == MONTH_DEC) begin
                            month_next = MONTH_JAN;
                            year_next  = year_reg + 14'd1;
                            // A year that wraps to zero starts a fresh 400-year cycle.
                            if (year_reg == '1) begin
                                pos_next = '0;
                            end else if (pos_reg[CYCLE_W-1:0] == CYCLE_LAST) begin
                                pos_next = '0;
                            end else begin
                                pos_next = pos_reg + 14'd1;
                            end
                        end else begin
                            month_next = month_reg + 4'd1;
                        end
                    end else begin
                        day_next  = reach[DAY_W-1:0];
                        left_next = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            left_reg    <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            left_reg    <= left_next;
        end
    end

    always_ff @(posedge aclk) begin
        day_reg   <= day_next;
        month_reg <= month_next;
        year_reg  <= year_next;
        pos_reg   <= pos_next;
        if (out_load) begin
            m_day_reg   <= day_reg;
            m_month_reg <= month_reg;
            m_year_reg  <= year_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_end_day   = m_day_reg;
    assign m_end_month = m_month_reg;
    assign m_end_year  = m_year_reg;

endmodule

FILE: sv/dad_checker.sv
// Port-level checks for date_add_days_top, attached by the bind below.
// Depends on dad_pkg for field widths and month constants.
`timescale 1ns / 1ps

module dad_checker
    import dad_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic [DAY_W-1:0]   s_start_day,
    input logic [MONTH_W-1:0] s_start_month,
    input logic [YEAR_W-1:0]  s_start_year,
    input logic [COUNT_W-1:0] s_days_to_add,
    input logic               m_valid,
    input logic               m_ready,
    input logic [DAY_W-1:0]   m_end_day,
    input logic [MONTH_W-1:0] m_end_month,
    input logic [YEAR_W-1:0]  m_end_year
);

    // One item in work: an input transfer closes the input side next cycle.
    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("s_ready stayed high after an input transfer");

    // A waiting input item holds until its transfer.
    a_input_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_start_day) && $stable(s_start_month)
            && $stable(s_start_year) && $stable(s_days_to_add))
        else $error("waiting input changed or dropped");

    // A stalled result holds.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_end_day) && $stable(m_end_month)
            && $stable(m_end_year))
        else $error("stalled result changed or dropped");

    // Every result has a nonzero day and a month from 1 to 12.
    a_valid_date: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_end_day != '0) && (m_end_month != '0) && (m_end_month <= MONTH_DEC))
        else $error("result is not a valid date");

    // Reset drops any pending result.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

endmodule

bind date_add_days_top dad_checker u_dad_checker (.*);
